FILE: rtl/core/quaternion_body_to_earth_rotation_unit_assert.svh
// ---------------------------------------------------------------------------
// quaternion body-to-earth rotation unit: assertion macros
// shared helpers for the concurrent checks of the rotation unit
// ---------------------------------------------------------------------------
`ifndef QUATERNION_BODY_TO_EARTH_ROTATION_UNIT_ASSERT_SVH
`define QUATERNION_BODY_TO_EARTH_ROTATION_UNIT_ASSERT_SVH

// overlapping implication, disabled while reset is asserted
`define QROT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, disabled while reset is asserted
`define QROT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

FILE: rtl/core/qrot_pkg.sv
// ---------------------------------------------------------------------------
// qrot_pkg
// shared constants, width helpers and stage enables of the rotation unit
// ---------------------------------------------------------------------------
package qrot_pkg;

	localparam int QUAT_BITS   = 16;
	localparam int NUM_ENTRIES = 9;
	localparam int VEC_LEN     = 3;
	localparam int NUM_VECS    = 2;
	localparam int NUM_LANES   = VEC_LEN * NUM_VECS;

	// matrix entries, row major
	localparam int M00 = 0;
	localparam int M01 = 1;
	localparam int M02 = 2;
	localparam int M10 = 3;
	localparam int M11 = 4;
	localparam int M12 = 5;
	localparam int M20 = 6;
	localparam int M21 = 7;
	localparam int M22 = 8;

	// width of an entry before rounding: room for 1.0 in q(2f) and 2*(a+b)
	function automatic int ext_width(input int frac);
		int base;
		base = (2 * QUAT_BITS + 3 > 2 * frac + 2) ? 2 * QUAT_BITS + 3 : 2 * frac + 2;
		return base + 1;
	endfunction

	// width of a rounded matrix entry
	function automatic int ent_width(input int frac);
		return ext_width(frac) - frac;
	endfunction

	// width of the sum of three entry * sample products
	function automatic int acc_width(input int frac, input int sample_bits);
		return ent_width(frac) + sample_bits + 2;
	endfunction

	typedef struct packed {
		logic mat_s1;
		logic mat_s2;
		logic mat_s3;
		logic lane_s4;
		logic lane_s5;
		logic out_s6;
	} stage_en_t;

endpackage

FILE: rtl/core/qrot_matrix.sv
// ---------------------------------------------------------------------------
// qrot_matrix
// three-stage build of the rounded rotation matrix from the quaternion
// ---------------------------------------------------------------------------
module qrot_matrix #(
	parameter int QUAT_FRAC_BITS = 14,
	localparam int EW = qrot_pkg::ext_width(QUAT_FRAC_BITS),
	localparam int MW = qrot_pkg::ent_width(QUAT_FRAC_BITS)
) (
	input  logic                                   clk,
	input  qrot_pkg::stage_en_t                    en,
	input  logic signed [qrot_pkg::QUAT_BITS-1:0]  quat_w,
	input  logic signed [qrot_pkg::QUAT_BITS-1:0]  quat_x,
	input  logic signed [qrot_pkg::QUAT_BITS-1:0]  quat_y,
	input  logic signed [qrot_pkg::QUAT_BITS-1:0]  quat_z,
	output logic signed [MW-1:0]                   ent [qrot_pkg::NUM_ENTRIES]
);

	localparam int PW = 2 * qrot_pkg::QUAT_BITS;
	localparam int SW = PW + 1;

	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_XY = 3;
	localparam int P_XZ = 4;
	localparam int P_YZ = 5;
	localparam int P_WX = 6;
	localparam int P_WY = 7;
	localparam int P_WZ = 8;
	localparam int NUM_PROD = 9;

	// 1.0 in q(2f) plus half an lsb of the rounding shift
	localparam logic signed [EW-1:0] DIAG_K =
		(EW'(1) << (2 * QUAT_FRAC_BITS)) + (EW'(1) << (QUAT_FRAC_BITS - 1));
	localparam logic signed [EW-1:0] HALF = EW'(1) << (QUAT_FRAC_BITS - 1);

	logic signed [PW-1:0] prod_s1 [NUM_PROD];
	logic signed [SW-1:0] sum_s2  [qrot_pkg::NUM_ENTRIES];
	logic signed [EW-1:0] ext     [qrot_pkg::NUM_ENTRIES];
	logic signed [MW-1:0] ent_s3  [qrot_pkg::NUM_ENTRIES];

	always_ff @(posedge clk) begin
		if (en.mat_s1) begin
			prod_s1[P_XX] <= quat_x * quat_x;
			prod_s1[P_YY] <= quat_y * quat_y;
			prod_s1[P_ZZ] <= quat_z * quat_z;
			prod_s1[P_XY] <= quat_x * quat_y;
			prod_s1[P_XZ] <= quat_x * quat_z;
			prod_s1[P_YZ] <= quat_y * quat_z;
			prod_s1[P_WX] <= quat_w * quat_x;
			prod_s1[P_WY] <= quat_w * quat_y;
			prod_s1[P_WZ] <= quat_w * quat_z;
		end
	end

	always_ff @(posedge clk) begin
		if (en.mat_s2) begin
			sum_s2[qrot_pkg::M00] <= SW'(prod_s1[P_YY]) + SW'(prod_s1[P_ZZ]);
			sum_s2[qrot_pkg::M01] <= SW'(prod_s1[P_XY]) - SW'(prod_s1[P_WZ]);
			sum_s2[qrot_pkg::M02] <= SW'(prod_s1[P_XZ]) + SW'(prod_s1[P_WY]);
			sum_s2[qrot_pkg::M10] <= SW'(prod_s1[P_XY]) + SW'(prod_s1[P_WZ]);
			sum_s2[qrot_pkg::M11] <= SW'(prod_s1[P_XX]) + SW'(prod_s1[P_ZZ]);
			sum_s2[qrot_pkg::M12] <= SW'(prod_s1[P_YZ]) - SW'(prod_s1[P_WX]);
			sum_s2[qrot_pkg::M20] <= SW'(prod_s1[P_XZ]) - SW'(prod_s1[P_WY]);
			sum_s2[qrot_pkg::M21] <= SW'(prod_s1[P_YZ]) + SW'(prod_s1[P_WX]);
			sum_s2[qrot_pkg::M22] <= SW'(prod_s1[P_XX]) + SW'(prod_s1[P_YY]);
		end
	end

	// diagonal: 1 - 2*s, others: 2*s, both with the rounding half folded in
	always_comb begin
		for (int i = 0; i < qrot_pkg::NUM_ENTRIES; i++) begin
			if (i == qrot_pkg::M00 || i == qrot_pkg::M11 || i == qrot_pkg::M22) begin
				ext[i] = DIAG_K - (EW'(sum_s2[i]) <<< 1);
			end else begin
				ext[i] = (EW'(sum_s2[i]) <<< 1) + HALF;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.mat_s3) begin
			for (int i = 0; i < qrot_pkg::NUM_ENTRIES; i++) begin
				ent_s3[i] <= MW'(ext[i] >>> QUAT_FRAC_BITS);
			end
		end
	end

	assign ent = ent_s3;

endmodule

FILE: rtl/core/qrot_lane.sv
// ---------------------------------------------------------------------------
// qrot_lane
// one matrix row times one vector: three products, then their sum
// ---------------------------------------------------------------------------
module qrot_lane #(
	parameter int QUAT_FRAC_BITS = 14,
	parameter int SAMPLE_BITS    = 16,
	localparam int MW  = qrot_pkg::ent_width(QUAT_FRAC_BITS),
	localparam int PRW = MW + SAMPLE_BITS,
	localparam int AW  = qrot_pkg::acc_width(QUAT_FRAC_BITS, SAMPLE_BITS)
) (
	input  logic                           clk,
	input  qrot_pkg::stage_en_t            en,
	input  logic signed [MW-1:0]           row [qrot_pkg::VEC_LEN],
	input  logic signed [SAMPLE_BITS-1:0]  vec [qrot_pkg::VEC_LEN],
	output logic signed [AW-1:0]           acc
);

	logic signed [PRW-1:0] prod_s4 [qrot_pkg::VEC_LEN];
	logic signed [AW-1:0]  acc_s5;

	always_ff @(posedge clk) begin
		if (en.lane_s4) begin
			for (int i = 0; i < qrot_pkg::VEC_LEN; i++) begin
				prod_s4[i] <= row[i] * vec[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.lane_s5) begin
			acc_s5 <= AW'(prod_s4[0]) + AW'(prod_s4[1]) + AW'(prod_s4[2]);
		end
	end

	assign acc = acc_s5;

endmodule

FILE: rtl/core/qrot_merge.sv
// ---------------------------------------------------------------------------
// qrot_merge
// rounds and saturates the lane sums and packs them into the output register
// ---------------------------------------------------------------------------
module qrot_merge #(
	parameter int QUAT_FRAC_BITS = 14,
	parameter int SAMPLE_BITS    = 16,
	localparam int AW    = qrot_pkg::acc_width(QUAT_FRAC_BITS, SAMPLE_BITS),
	localparam int OUT_W = ((qrot_pkg::NUM_LANES * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                   clk,
	input  qrot_pkg::stage_en_t    en,
	input  logic signed [AW-1:0]   acc [qrot_pkg::NUM_LANES],
	output logic [OUT_W-1:0]       tdata
);

	localparam int XW = AW + 1;
	localparam int RW = XW - QUAT_FRAC_BITS;
	localparam logic signed [XW-1:0] HALF    = XW'(1) << (QUAT_FRAC_BITS - 1);
	localparam logic signed [RW-1:0] SAT_MAX = RW'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [RW-1:0] SAT_MIN = RW'(-(longint'(1) << (SAMPLE_BITS - 1)));

	logic signed [RW-1:0]          rnd [qrot_pkg::NUM_LANES];
	logic        [SAMPLE_BITS-1:0] res [qrot_pkg::NUM_LANES];
	logic        [OUT_W-1:0]       tdata_d;
	logic        [OUT_W-1:0]       tdata_s6;

	always_comb begin
		tdata_d = '0;
		for (int i = 0; i < qrot_pkg::NUM_LANES; i++) begin
			rnd[i] = RW'((XW'(acc[i]) + HALF) >>> QUAT_FRAC_BITS);
			if (rnd[i] > SAT_MAX) begin
				res[i] = SAT_MAX[SAMPLE_BITS-1:0];
			end else if (rnd[i] < SAT_MIN) begin
				res[i] = SAT_MIN[SAMPLE_BITS-1:0];
			end else begin
				res[i] = rnd[i][SAMPLE_BITS-1:0];
			end
			tdata_d[i*SAMPLE_BITS +: SAMPLE_BITS] = res[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en.out_s6) begin
			tdata_s6 <= tdata_d;
		end
	end

	assign tdata = tdata_s6;

endmodule

FILE: rtl/core/quaternion_body_to_earth_rotation_unit.sv
// ---------------------------------------------------------------------------
// quaternion body-to-earth rotation unit
// rotates one acceleration and one angular rate vector by the rotation
// matrix of an attitude quaternion, with rounding and 16-bit saturation
//
// s_* channel: one item is a quaternion plus both body-frame vectors.
// m_* channel: one item is both vectors in the earth frame.
// the six stages are quaternion products, entry sums, rounded entries,
// lane products, lane sums and round/saturate; m_tvalid rises once an
// accepted item reaches the last stage.
// throughput is one item per cycle unless m_tready stalls; six lanes (three
// rows for each vector) work side by side on the matrix, which is built once
// per item. a stalled m_tready holds the output register; earlier stages keep
// filling their empty slots, and s_tready falls only when all six stages
// hold items. reset clears every stage valid bit, so no item is in flight
// afterwards.
// ---------------------------------------------------------------------------
module quaternion_body_to_earth_rotation_unit #(
	parameter int QUAT_FRAC_BITS = 14,
	parameter int SAMPLE_BITS    = 16,
	localparam int IN_W  =
		((4 * qrot_pkg::QUAT_BITS + qrot_pkg::NUM_LANES * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((qrot_pkg::NUM_LANES * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// earth_accel_x, earth_accel_y, earth_accel_z, earth_rate_x, earth_rate_y, earth_rate_z
	output logic [OUT_W-1:0] m_tdata
);

	localparam int QB         = qrot_pkg::QUAT_BITS;
	localparam int NUM_STAGES = 6;
	localparam int MW         = qrot_pkg::ent_width(QUAT_FRAC_BITS);
	localparam int AW         = qrot_pkg::acc_width(QUAT_FRAC_BITS, SAMPLE_BITS);
	localparam int SMP_BASE   = 4 * QB;

	logic [NUM_STAGES-1:0]         vld_q;
	logic [NUM_STAGES-1:0]         rdy;
	qrot_pkg::stage_en_t           en;

	logic signed [SAMPLE_BITS-1:0] smp    [qrot_pkg::NUM_LANES];
	logic signed [SAMPLE_BITS-1:0] vec_s1 [qrot_pkg::NUM_LANES];
	logic signed [SAMPLE_BITS-1:0] vec_s2 [qrot_pkg::NUM_LANES];
	logic signed [SAMPLE_BITS-1:0] vec_s3 [qrot_pkg::NUM_LANES];
	logic signed [MW-1:0]          ent    [qrot_pkg::NUM_ENTRIES];
	logic signed [AW-1:0]          acc    [qrot_pkg::NUM_LANES];

	// a stage takes a new item when it is empty or its item moves on
	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || m_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign en.mat_s1  = rdy[0];
	assign en.mat_s2  = rdy[1];
	assign en.mat_s3  = rdy[2];
	assign en.lane_s4 = rdy[3];
	assign en.lane_s5 = rdy[4];
	assign en.out_s6  = rdy[5];

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[NUM_STAGES-1];

	// sample vectors ride along while the matrix is built
	always_comb begin
		for (int i = 0; i < qrot_pkg::NUM_LANES; i++) begin
			smp[i] = s_tdata[SMP_BASE + i*SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en.mat_s1) begin
			vec_s1 <= smp;
		end
		if (en.mat_s2) begin
			vec_s2 <= vec_s1;
		end
		if (en.mat_s3) begin
			vec_s3 <= vec_s2;
		end
	end

	qrot_matrix #(
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
	) u_matrix (
		.clk    (clk),
		.en     (en),
		.quat_w (s_tdata[0*QB +: QB]),
		.quat_x (s_tdata[1*QB +: QB]),
		.quat_y (s_tdata[2*QB +: QB]),
		.quat_z (s_tdata[3*QB +: QB]),
		.ent    (ent)
	);

	for (genvar g = 0; g < qrot_pkg::NUM_LANES; g++) begin : g_lane
		localparam int ROW  = g % qrot_pkg::VEC_LEN;
		localparam int VSEL = g / qrot_pkg::VEC_LEN;

		logic signed [MW-1:0]          row_w [qrot_pkg::VEC_LEN];
		logic signed [SAMPLE_BITS-1:0] vec_w [qrot_pkg::VEC_LEN];

		for (genvar j = 0; j < qrot_pkg::VEC_LEN; j++) begin : g_tap
			assign row_w[j] = ent[ROW*qrot_pkg::VEC_LEN + j];
			assign vec_w[j] = vec_s3[VSEL*qrot_pkg::VEC_LEN + j];
		end

		qrot_lane #(
			.QUAT_FRAC_BITS(QUAT_FRAC_BITS),
			.SAMPLE_BITS   (SAMPLE_BITS)
		) u_lane (
			.clk (clk),
			.en  (en),
			.row (row_w),
			.vec (vec_w),
			.acc (acc[g])
		);
	end

	qrot_merge #(
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS),
		.SAMPLE_BITS   (SAMPLE_BITS)
	) u_merge (
		.clk   (clk),
		.en    (en),
		.acc   (acc),
		.tdata (m_tdata)
	);

endmodule

FILE: rtl/core/qrot_checker.sv
// ---------------------------------------------------------------------------
// qrot_checker
// port-level checks of the rotation unit, attached by bind
// ---------------------------------------------------------------------------
`include "quaternion_body_to_earth_rotation_unit_assert.svh"

module qrot_checker #(
	parameter int DATA_W = 96
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata
);

	// a stalled result stays put
	`QROT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// input side only blocks when the whole pipe is full behind a stalled output
	`QROT_ASSERT_IMP(a_full_only, clk, arst_n, !s_tready, m_tvalid && !m_tready)

	// with the output draining, an accepted item shows up at m_tvalid once it has passed every stage
	`QROT_ASSERT_NEXT(a_latency, clk, arst_n, s_tvalid && s_tready ##1 m_tready [*5], m_tvalid)

endmodule

bind quaternion_body_to_earth_rotation_unit qrot_checker #(
	.DATA_W(OUT_W)
) u_qrot_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion body-to-earth rotation unit testbench
// drives quaternion and sensor vector items through the stream input with
// random gaps and output stalls; every output item is checked lane by lane
// against a 64-bit integer model of the rounded rotation matrix product
// ---------------------------------------------------------------------------

localparam int QUAT_FRAC = 14;
localparam int SAMPLE_W  = 16;
localparam int IN_W      = 4 * qrot_pkg::QUAT_BITS + qrot_pkg::NUM_LANES * SAMPLE_W;
localparam int OUT_W     = qrot_pkg::NUM_LANES * SAMPLE_W;
localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
localparam longint SAT_LO = -SAT_HI - 1;

// packed from the top down so that quat_w lands in the lowest bits
typedef struct packed {
	logic signed [SAMPLE_W-1:0] rate_z;
	logic signed [SAMPLE_W-1:0] rate_y;
	logic signed [SAMPLE_W-1:0] rate_x;
	logic signed [SAMPLE_W-1:0] accel_z;
	logic signed [SAMPLE_W-1:0] accel_y;
	logic signed [SAMPLE_W-1:0] accel_x;
	logic signed [15:0]         quat_z;
	logic signed [15:0]         quat_y;
	logic signed [15:0]         quat_x;
	logic signed [15:0]         quat_w;
} sample_set_t;

// round half up while dropping the quaternion fraction bits
function automatic longint round_q(input longint v);
	return (v + (longint'(1) <<< (QUAT_FRAC - 1))) >>> QUAT_FRAC;
endfunction

function automatic logic [OUT_W-1:0] rotate_to_earth(input sample_set_t s);
	longint w, x, y, z, unity, acc;
	longint ent[9];
	longint mat[9];
	longint vec[6];
	logic [OUT_W-1:0] flat;
	int i, k, r;
	w = $signed(s.quat_w);
	x = $signed(s.quat_x);
	y = $signed(s.quat_y);
	z = $signed(s.quat_z);
	vec[0] = $signed(s.accel_x);
	vec[1] = $signed(s.accel_y);
	vec[2] = $signed(s.accel_z);
	vec[3] = $signed(s.rate_x);
	vec[4] = $signed(s.rate_y);
	vec[5] = $signed(s.rate_z);
	unity = longint'(1) <<< (2 * QUAT_FRAC);
	ent[0] = unity - 2 * (y * y + z * z);
	ent[1] = 2 * (x * y - w * z);
	ent[2] = 2 * (x * z + w * y);
	ent[3] = 2 * (x * y + w * z);
	ent[4] = unity - 2 * (x * x + z * z);
	ent[5] = 2 * (y * z - w * x);
	ent[6] = 2 * (x * z - w * y);
	ent[7] = 2 * (y * z + w * x);
	ent[8] = unity - 2 * (x * x + y * y);
	for (i = 0; i < 9; i++)
		mat[i] = round_q(ent[i]);
	flat = '0;
	for (k = 0; k < 2; k++) begin
		for (r = 0; r < 3; r++) begin
			acc = mat[3*r] * vec[3*k] + mat[3*r+1] * vec[3*k+1] + mat[3*r+2] * vec[3*k+2];
			acc = round_q(acc);
			if (acc > SAT_HI)
				acc = SAT_HI;
			else if (acc < SAT_LO)
				acc = SAT_LO;
			flat[SAMPLE_W*(3*k+r) +: SAMPLE_W] = acc[SAMPLE_W-1:0];
		end
	end
	return flat;
endfunction

class earth_frame_scoreboard;
	logic [OUT_W-1:0] earth_due[$];
	int failures;
	string lane_tag[qrot_pkg::NUM_LANES] = '{"earth_accel_x", "earth_accel_y",
		"earth_accel_z", "earth_rate_x", "earth_rate_y", "earth_rate_z"};

	function new();
		failures = 0;
	endfunction

	function void note_sample(input sample_set_t s);
		earth_due.push_back(rotate_to_earth(s));
	endfunction

	function int due_count();
		return earth_due.size();
	endfunction

	function void check_earth(input logic [OUT_W-1:0] got);
		logic [OUT_W-1:0] want;
		int lane;
		if (earth_due.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected output item %h", got);
			return;
		end
		want = earth_due.pop_front();
		for (lane = 0; lane < qrot_pkg::NUM_LANES; lane++) begin
			if (got[SAMPLE_W*lane +: SAMPLE_W] !== want[SAMPLE_W*lane +: SAMPLE_W]) begin
				failures++;
				if (failures <= 10)
					$display("%s mismatch: expected %0d, got %0d", lane_tag[lane],
						$signed(want[SAMPLE_W*lane +: SAMPLE_W]),
						$signed(got[SAMPLE_W*lane +: SAMPLE_W]));
			end
		end
	endfunction
endclass

module testbench;

	localparam int RANDOM_ITEMS = 1350;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 12;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	bit steady;
	earth_frame_scoreboard sb;

	quaternion_body_to_earth_rotation_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic sample_set_t make_sample(input int w, input int x, input int y,
		input int z, input int ax, input int ay, input int az, input int rx, input int ry,
		input int rz);
		sample_set_t s;
		s.quat_w  = w[15:0];
		s.quat_x  = x[15:0];
		s.quat_y  = y[15:0];
		s.quat_z  = z[15:0];
		s.accel_x = ax[SAMPLE_W-1:0];
		s.accel_y = ay[SAMPLE_W-1:0];
		s.accel_z = az[SAMPLE_W-1:0];
		s.rate_x  = rx[SAMPLE_W-1:0];
		s.rate_y  = ry[SAMPLE_W-1:0];
		s.rate_z  = rz[SAMPLE_W-1:0];
		return s;
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_axis();
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if (pick < 70)
			return SAMPLE_W'($urandom);
		if (pick < 85) begin
			case ($urandom_range(0, 4))
				0: v = -32768;
				1: v = 32767;
				2: v = 0;
				3: v = -1;
				default: v = 1;
			endcase
			return v[SAMPLE_W-1:0];
		end
		v = int'($urandom_range(0, 1024)) - 512;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic sample_set_t random_sample();
		sample_set_t s;
		int pick, i;
		int q[4];
		real a[4];
		real norm;
		int axis_vals[7] = '{0, 16384, -16384, 11585, -11585, 8192, -8192};
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			// unit quaternion with random direction
			for (i = 0; i < 4; i++)
				a[i] = real'(int'($urandom_range(0, 65534)) - 32767);
			norm = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]);
			if (norm < 1.0) begin
				a[0] = 1.0;
				norm = 1.0;
			end
			for (i = 0; i < 4; i++)
				q[i] = int'(a[i] / norm * 16384.0);
		end else if (pick < 70) begin
			for (i = 0; i < 4; i++)
				q[i] = int'($urandom_range(0, 32768)) - 16384;
		end else if (pick < 85) begin
			for (i = 0; i < 4; i++)
				q[i] = int'($urandom_range(0, 65535));
		end else begin
			for (i = 0; i < 4; i++)
				q[i] = axis_vals[$urandom_range(0, 6)];
		end
		s.quat_w  = q[0][15:0];
		s.quat_x  = q[1][15:0];
		s.quat_y  = q[2][15:0];
		s.quat_z  = q[3][15:0];
		s.accel_x = random_axis();
		s.accel_y = random_axis();
		s.accel_z = random_axis();
		s.rate_x  = random_axis();
		s.rate_y  = random_axis();
		s.rate_z  = random_axis();
		return s;
	endfunction

	task automatic push_sample(input sample_set_t s);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 12) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= s;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	// output side back-pressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= steady || ($urandom_range(0, 99) >= 12);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_earth(m_tdata);
	end

	// ends the run when no item moves on either side for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("testbench: errors");
		$finish;
	end

	initial begin
		int n;
		sb       = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		steady   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// identity and zero quaternion, full-scale vectors
		push_sample(make_sample(16384, 0, 0, 0, 32767, -32768, 0, 1, -1, 12345));
		push_sample(make_sample(0, 0, 0, 0, -32768, 32767, -32768, 32767, 0, -1));
		// half turns about each axis
		push_sample(make_sample(0, 16384, 0, 0, 32767, -32768, -32768, 100, 200, -300));
		push_sample(make_sample(0, 0, 16384, 0, -32768, 32767, 32767, -100, 200, 300));
		push_sample(make_sample(0, 0, 0, 16384, 32767, 32767, -32768, 1000, -2000, 3000));
		// quarter turns
		push_sample(make_sample(11585, 0, 0, 11585, 32767, -32768, 1234, -5, 7, 9));
		push_sample(make_sample(11585, 11585, 0, 0, -32768, 32767, -4321, 5, -7, 9));
		push_sample(make_sample(11585, 0, 11585, 0, 20000, -20000, 30000, 32767, 32767, 32767));
		push_sample(make_sample(-11585, 0, 0, 11585, 0, 32767, 0, -32768, 0, 32767));
		// unnormalized quaternions, some of them driving lanes into saturation
		push_sample(make_sample(-32768, -32768, -32768, -32768,
			-32768, -32768, -32768, 32767, 32767, 32767));
		push_sample(make_sample(32767, 32767, 32767, 32767,
			32767, 32767, 32767, -32768, -32768, -32768));
		push_sample(make_sample(16384, 16384, 16384, 16384,
			32767, -32768, 32767, -32768, 32767, -32768));
		push_sample(make_sample(-16384, -16384, 16384, -16384,
			-32768, -32768, -32768, -32768, -32768, -32768));
		push_sample(make_sample(-32768, 0, 0, 0, 32767, -32768, 1, -1, 2, -2));
		push_sample(make_sample(8192, 8192, 8192, 8192, 32767, 32767, 32767, 32767, 32767, 32767));
		// half-lsb products: ties round toward plus infinity
		push_sample(make_sample(0, 0, 8192, 0, 1, -1, 3, -1, 1, -3));
		push_sample(make_sample(1, -1, 1, -1, 1, 1, 1, -1, -1, -1));
		// bit patterns
		push_sample(make_sample('h5555, 'hAAAA, 'h5555, 'hAAAA,
			'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
		push_sample(make_sample('hAAAA, 'h5555, 'hAAAA, 'h5555,
			'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA));
		push_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		push_sample(make_sample('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF,
			'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// back-to-back window with no gaps or stalls
			steady = (n >= 500 && n < 800);
			push_sample(random_sample());
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (sb.due_count() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.due_count() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/qrot_pkg.sv
rtl/core/qrot_matrix.sv
rtl/core/qrot_lane.sv
rtl/core/qrot_merge.sv
rtl/core/quaternion_body_to_earth_rotation_unit.sv
rtl/core/qrot_checker.sv
tb/testbench.sv
